>>> rtl/odc_pkg.sv
// Shared types and constants for the nonzero coordinate emitter.
`timescale 1ns / 1ps

package odc_pkg;

  localparam int MAX_DIMS    = 4;
  localparam int EXTENT_BITS = 16;

  localparam int ELEM_W       = 64;
  localparam int MATCH_W      = 32;
  localparam int COORD_W      = 16;
  localparam int NUM_COORDS   = 4;
  localparam int ELEM_TYPE_W  = 4;
  localparam int DIMS_W       = 3;
  localparam int CFG_DATA_W   = EXTENT_BITS;
  localparam int CFG_IDX_W    = $clog2(2 + MAX_DIMS);

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ELEM_TYPE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DIMS_USED   = CFG_IDX_W'(1);
  localparam int                   REG_EXTENT_BASE = 2;

  typedef enum logic [ELEM_TYPE_W-1:0] {
    ET_BOOL = 4'd0,
    ET_I8   = 4'd1,
    ET_I16  = 4'd2,
    ET_I32  = 4'd3,
    ET_I64  = 4'd4,
    ET_U8   = 4'd5,
    ET_U16  = 4'd6,
    ET_U32  = 4'd7,
    ET_U64  = 4'd8,
    ET_F32  = 4'd9,
    ET_F64  = 4'd10,
    ET_C64  = 4'd11,
    ET_C128 = 4'd12
  } odc_elem_t;

  typedef struct packed {
    logic [ELEM_W-1:0] elem_lo;
    logic [ELEM_W-1:0] elem_hi;
  } odc_in_t;

  typedef struct packed {
    logic [MATCH_W-1:0] match_number;
    logic [COORD_W-1:0] coord_0;
    logic [COORD_W-1:0] coord_1;
    logic [COORD_W-1:0] coord_2;
    logic [COORD_W-1:0] coord_3;
    logic               final_element;
  } odc_out_t;

  // Carry and end-of-array flags passed from the inner cell to the outer one
  typedef struct packed {
    logic inc;
    logic all_end;
  } odc_link_t;

  typedef struct packed {
    logic used;
    logic step;
    logic clear;
    logic ext_we;
  } odc_cell_ctrl_t;

endpackage

>>> rtl/odc_truth.sv
// Truthiness test of one element according to its element type.
`timescale 1ns / 1ps

module odc_truth import odc_pkg::*; (
  input  logic [ELEM_TYPE_W-1:0] elem_type,
  input  logic [ELEM_W-1:0]      elem_lo,
  input  logic [ELEM_W-1:0]      elem_hi,
  output logic                   hit
);

  logic lo8_nz, lo16_nz, lo32_nz, lo64_nz;
  logic f32_lo_nz, f32_hi_nz, f64_lo_nz, f64_hi_nz;

  assign lo8_nz    = |elem_lo[7:0];
  assign lo16_nz   = |elem_lo[15:0];
  assign lo32_nz   = |elem_lo[31:0];
  assign lo64_nz   = |elem_lo;
  // sign bit ignored: minus zero is false, NaN is true
  assign f32_lo_nz = |elem_lo[30:0];
  assign f32_hi_nz = |elem_lo[62:32];
  assign f64_lo_nz = |elem_lo[62:0];
  assign f64_hi_nz = |elem_hi[62:0];

  always_comb begin
    unique case (odc_elem_t'(elem_type))
      ET_BOOL, ET_I8, ET_U8: hit = lo8_nz;
      ET_I16, ET_U16:        hit = lo16_nz;
      ET_I32, ET_U32:        hit = lo32_nz;
      ET_I64, ET_U64:        hit = lo64_nz;
      ET_F32:                hit = f32_lo_nz;
      ET_F64:                hit = f64_lo_nz;
      ET_C64:                hit = f32_lo_nz | f32_hi_nz;
      ET_C128:               hit = f64_lo_nz | f64_hi_nz;
      default:               hit = 1'b0;
    endcase
  end

endmodule

>>> rtl/odc_cell.sv
// One odometer digit: holds a dimension's extent and its current index.
`timescale 1ns / 1ps

module odc_cell import odc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  odc_cell_ctrl_t         ctrl,
  input  logic [EXTENT_BITS-1:0] wr_data,
  input  odc_link_t              link_in,
  output odc_link_t              link_out,
  output logic [EXTENT_BITS-1:0] pos
);

  logic [EXTENT_BITS-1:0] pos_r, pos_nxt;
  logic [EXTENT_BITS-1:0] ext_r, ext_nxt;
  logic [EXTENT_BITS-1:0] end_idx;
  logic                   at_end;

  // zero extent acts as one; an index past the end also ends the dimension
  assign end_idx = (ext_r == '0) ? '0 : ext_r - EXTENT_BITS'(1);
  assign at_end  = pos_r >= end_idx;
  assign pos     = pos_r;

  always_comb begin
    pos_nxt = pos_r;
    ext_nxt = ext_r;
    if (ctrl.ext_we) begin
      ext_nxt = wr_data;
    end
    if (ctrl.used) begin
      link_out.inc     = link_in.inc & at_end;
      link_out.all_end = link_in.all_end & at_end;
    end else begin
      link_out = link_in;
    end
    priority if (ctrl.clear) begin
      pos_nxt = '0;
    end else if (ctrl.step && ctrl.used && link_in.inc) begin
      pos_nxt = at_end ? '0 : pos_r + EXTENT_BITS'(1);
    end else begin
      pos_nxt = pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      ext_r <= EXTENT_BITS'(1);
    end else begin
      pos_r <= pos_nxt;
      ext_r <= ext_nxt;
    end
  end

endmodule

>>> rtl/nonzero_coordinate_emitter_unit.sv
// Top level: odometer cell row, truth test, match counter and output register.
//
//  channel | ports                          | beat
//  --------+--------------------------------+-------------------------------------
//  in      | in_valid, in_stall, in_data    | one array element, row-major order
//  out     | out_valid, out_stall, out_data | coordinates of one true element
//  cfg     | cfg_we, cfg_index, cfg_data    | one register write
//
// One element per cycle while in_stall is low; the odometer carry ripples through
// the cell row and truth test in the same cycle; results appear in the next cycle.
// in_stall rises only while the output register holds a beat that is stalled.
// Reset (synchronous, rst_n low) clears the indices and the match count and loads
// element_type 0, dims_used 1 and all extents 1.
`timescale 1ns / 1ps

module nonzero_coordinate_emitter_unit import odc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  odc_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output odc_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [ELEM_TYPE_W-1:0] elem_type_r, elem_type_nxt;
  logic [DIMS_W-1:0]      dims_used_r, dims_used_nxt;
  logic [MATCH_W-1:0]     matches_r, matches_nxt;
  logic                   out_valid_r, out_valid_nxt;
  odc_out_t               out_data_r, out_data_nxt;

  logic                   accept;
  logic                   hit;
  logic                   last;
  odc_link_t              link [MAX_DIMS+1];
  odc_cell_ctrl_t         cell_ctrl [MAX_DIMS];
  logic [EXTENT_BITS-1:0] pos [MAX_DIMS];
  logic [COORD_W-1:0]     coord [NUM_COORDS];

  assign in_stall  = out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  odc_truth u_truth (
    .elem_type (elem_type_r),
    .elem_lo   (in_data.elem_lo),
    .elem_hi   (in_data.elem_hi),
    .hit       (hit)
  );

  // innermost cell always sees a carry; unused cells pass the chain through
  assign link[MAX_DIMS] = '{inc: 1'b1, all_end: 1'b1};
  assign last           = link[0].all_end;

  for (genvar d = 0; d < MAX_DIMS; d++) begin : g_cell
    assign cell_ctrl[d] = '{
      used:   (32'(dims_used_r) > 32'(d)),
      step:   accept & ~last,
      clear:  accept & last,
      ext_we: cfg_we & (cfg_index == CFG_IDX_W'(REG_EXTENT_BASE + d))
    };

    odc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (cell_ctrl[d]),
      .wr_data  (cfg_data),
      .link_in  (link[d+1]),
      .link_out (link[d]),
      .pos      (pos[d])
    );
  end

  for (genvar c = 0; c < NUM_COORDS; c++) begin : g_coord
    if (c < MAX_DIMS) begin : g_live
      logic [COORD_W+EXTENT_BITS-1:0] pos_wide;
      assign pos_wide = {{COORD_W{1'b0}}, pos[c]};
      assign coord[c] = cell_ctrl[c].used ? pos_wide[COORD_W-1:0] : '0;
    end else begin : g_dead
      assign coord[c] = '0;
    end
  end

  always_comb begin
    elem_type_nxt = elem_type_r;
    dims_used_nxt = dims_used_r;
    if (cfg_we && cfg_index == REG_ELEM_TYPE) begin
      elem_type_nxt = cfg_data[ELEM_TYPE_W-1:0];
    end
    if (cfg_we && cfg_index == REG_DIMS_USED) begin
      dims_used_nxt = cfg_data[DIMS_W-1:0];
    end
  end

  always_comb begin
    matches_nxt = matches_r;
    if (accept) begin
      priority if (last) begin
        matches_nxt = '0;
      end else if (hit && matches_r != '1) begin
        matches_nxt = matches_r + MATCH_W'(1);
      end else begin
        matches_nxt = matches_r;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
    // load a result beat for a true element
    if (accept && hit) begin
      out_valid_nxt              = 1'b1;
      out_data_nxt.match_number  = matches_r;
      out_data_nxt.coord_0       = coord[0];
      out_data_nxt.coord_1       = coord[1];
      out_data_nxt.coord_2       = coord[2];
      out_data_nxt.coord_3       = coord[3];
      out_data_nxt.final_element = last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elem_type_r <= '0;
      dims_used_r <= DIMS_W'(1);
      matches_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      elem_type_r <= elem_type_nxt;
      dims_used_r <= dims_used_nxt;
      matches_r   <= matches_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && last |=> matches_r == '0 && pos[0] == '0)
    else $error("counters not cleared after final element");

  a_hit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    accept && hit |=> out_valid_r && out_data_r.match_number == $past(matches_r))
    else $error("true element produced no result beat");

  a_count_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !last |=> matches_r >= $past(matches_r))
    else $error("match count went backwards within an array");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r && out_stall)
    else $error("input stalled with free output register");

endmodule

>>> bench/tb_top.sv
// Self-checking bench for the nonzero coordinate emitter: directed rows, random arrays, short sweep.
`timescale 1ns / 1ps

module tb_top;
  import odc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_0 = CFG_IDX_W'(REG_EXTENT_BASE);
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_1 = CFG_IDX_W'(REG_EXTENT_BASE + 1);
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_2 = CFG_IDX_W'(REG_EXTENT_BASE + 2);
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_3 = CFG_IDX_W'(REG_EXTENT_BASE + 3);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE     = CFG_IDX_W'(REG_EXTENT_BASE + MAX_DIMS);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_TOP = '1;
  localparam int SETTLE_CYCLES = 3;
  localparam int MAX_REPORTS   = 50;
  localparam int ARRAY_CAP     = 64;
  localparam int SWEEP_LEN     = 40;

  typedef enum bit {ROW_WRITE, ROW_ELEM} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  data;
    logic [ELEM_W-1:0]      lo;
    logic [ELEM_W-1:0]      hi;
    bit                     known;
    bit                     known_hit;
    odc_out_t               known_res;
  } plan_row_t;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  odc_in_t               in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  odc_out_t              out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // Predictor copy of the registers and the odometer
  logic [ELEM_TYPE_W-1:0] cur_type   = ET_BOOL;
  logic [DIMS_W-1:0]      cur_dims   = 1;
  logic [EXTENT_BITS-1:0] cur_extent [MAX_DIMS] = '{default: 1};
  logic [EXTENT_BITS-1:0] odo_pos    [MAX_DIMS] = '{default: 0};
  logic [MATCH_W-1:0]     hit_count  = '0;

  odc_out_t pending_coords[$];
  int       mismatches    = 0;
  int       send_idle_pct = 31;
  int       recv_idle_pct = 64;

  // Hand-written expectation for the beat currently on the input
  bit       row_known     = 1'b0;
  bit       row_known_hit = 1'b0;
  odc_out_t row_known_res = '0;

  nonzero_coordinate_emitter_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic int dims_in_use();
    return (cur_dims > MAX_DIMS) ? MAX_DIMS : int'(cur_dims);
  endfunction

  // Zero extent behaves as one
  function automatic logic [EXTENT_BITS:0] span(int d);
    return (cur_extent[d] == '0) ? (EXTENT_BITS+1)'(1) : {1'b0, cur_extent[d]};
  endfunction

  function automatic void predict_coordinates(input logic [ELEM_W-1:0] lo, hi,
                                              output bit hit, output odc_out_t res);
    int               nd;
    bit               last;
    logic [COORD_W-1:0] c [NUM_COORDS];
    nd   = dims_in_use();
    last = 1'b1;
    for (int d = 0; d < nd; d++) begin
      if ({1'b0, odo_pos[d]} + 1 < span(d)) last = 1'b0;
    end
    case (cur_type)
      ET_BOOL, ET_I8, ET_U8: hit = lo[7:0] != '0;
      ET_I16, ET_U16:        hit = lo[15:0] != '0;
      ET_I32, ET_U32:        hit = lo[31:0] != '0;
      ET_I64, ET_U64:        hit = lo != '0;
      // floats ignore the sign bit
      ET_F32:                hit = lo[30:0] != '0;
      ET_F64:                hit = lo[62:0] != '0;
      ET_C64:                hit = (lo[30:0] != '0) || (lo[62:32] != '0);
      ET_C128:               hit = (lo[62:0] != '0) || (hi[62:0] != '0);
      default:               hit = 1'b0;
    endcase
    for (int d = 0; d < NUM_COORDS; d++) c[d] = (d < nd) ? odo_pos[d] : '0;
    res = '{match_number: hit_count, coord_0: c[0], coord_1: c[1], coord_2: c[2],
            coord_3: c[3], final_element: last};
    if (last) begin
      odo_pos   = '{default: '0};
      hit_count = '0;
    end else begin
      if (hit && hit_count != '1) hit_count++;
      // last used dimension moves fastest
      for (int d = nd - 1; d >= 0; d--) begin
        if ({1'b0, odo_pos[d]} + 1 < span(d)) begin
          odo_pos[d]++;
          break;
        end
        odo_pos[d] = '0;
      end
    end
  endfunction

  function automatic void check_field(string name, logic [MATCH_W-1:0] want, got);
    if (want !== got) begin
      if (mismatches < MAX_REPORTS)
        $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : scoreboard
    bit       hit;
    odc_out_t res;
    odc_out_t want;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ELEM_TYPE: cur_type = cfg_data[ELEM_TYPE_W-1:0];
          REG_DIMS_USED: cur_dims = cfg_data[DIMS_W-1:0];
          default: begin
            if (cfg_index >= REG_EXTENT_BASE && cfg_index < REG_EXTENT_BASE + MAX_DIMS)
              cur_extent[cfg_index - REG_EXTENT_BASE] = cfg_data;
          end
        endcase
      end
      if (in_valid && !in_stall) begin
        predict_coordinates(in_data.elem_lo, in_data.elem_hi, hit, res);
        if (row_known) begin
          hit = row_known_hit;
          res = row_known_res;
        end
        if (hit) pending_coords.push_back(res);
      end
      if (out_valid && !out_stall) begin
        if (pending_coords.size() == 0) begin
          if (mismatches < MAX_REPORTS)
            $display("%0t ns: expected no beat, got %p", $time, out_data);
          mismatches++;
        end else begin
          want = pending_coords.pop_front();
          check_field("match_number", want.match_number, out_data.match_number);
          check_field("coord_0", want.coord_0, out_data.coord_0);
          check_field("coord_1", want.coord_1, out_data.coord_1);
          check_field("coord_2", want.coord_2, out_data.coord_2);
          check_field("coord_3", want.coord_3, out_data.coord_3);
          check_field("final_element", want.final_element, out_data.final_element);
        end
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Called and returns at a falling edge; the beat has been taken on return
  task automatic push_elem(input logic [ELEM_W-1:0] lo, hi, input bit known = 1'b0,
                           input bit known_hit = 1'b0, input odc_out_t known_res = '0);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_data       <= '{elem_lo: lo, elem_hi: hi};
    row_known     = known;
    row_known_hit = known_hit;
    row_known_res = known_res;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Hold the input until every pending beat is out, then let the pipe settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_coords.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic plan_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    return '{kind: ROW_WRITE, idx: idx, data: data, lo: '0, hi: '0, known: 1'b0,
             known_hit: 1'b0, known_res: '0};
  endfunction

  function automatic plan_row_t elem_row(logic [ELEM_W-1:0] lo, hi, bit known = 1'b0,
                                         bit hit = 1'b0, logic [MATCH_W-1:0] m = '0,
                                         logic [COORD_W-1:0] c0 = '0, c1 = '0, c2 = '0,
                                         logic [COORD_W-1:0] c3 = '0, bit fin = 1'b0);
    return '{kind: ROW_ELEM, idx: '0, data: '0, lo: lo, hi: hi, known: known, known_hit: hit,
             known_res: '{match_number: m, coord_0: c0, coord_1: c1, coord_2: c2,
                          coord_3: c3, final_element: fin}};
  endfunction

  task automatic run_random_arrays(input int n_items);
    int                    fed;
    int                    len;
    int                    zero_pct;
    logic [CFG_DATA_W-1:0] val;
    logic [ELEM_W-1:0]     lo;
    logic [ELEM_W-1:0]     hi;
    fed = 0;
    while (fed < n_items) begin
      drain_results();
      if ($urandom_range(3) != 0) begin
        val = $urandom_range(1) ? CFG_DATA_W'($urandom) : '0;
        val[ELEM_TYPE_W-1:0] = ($urandom_range(7) == 0) ? ELEM_TYPE_W'($urandom_range(15, 13))
                                                         : ELEM_TYPE_W'($urandom_range(12));
        write_reg(REG_ELEM_TYPE, val);
      end
      if ($urandom_range(2) != 0) begin
        val = $urandom_range(1) ? CFG_DATA_W'($urandom) : '0;
        val[DIMS_W-1:0] = ($urandom_range(9) == 0) ? DIMS_W'($urandom_range(7, 5))
                                                    : DIMS_W'($urandom_range(4));
        write_reg(REG_DIMS_USED, val);
      end
      for (int d = 0; d < MAX_DIMS; d++) begin
        if ($urandom_range(2) != 0) begin
          case ($urandom_range(19))
            0:       val = '0;
            1:       val = CFG_DATA_W'($urandom);
            2:       val = '1;
            default: val = CFG_DATA_W'($urandom_range(4, 1));
          endcase
          write_reg(CFG_IDX_W'(REG_EXTENT_BASE + d), val);
        end
      end
      // Arrays longer than the cap are cut short and picked up under the next setting
      len = 1;
      for (int d = 0; d < dims_in_use(); d++) begin
        len = len * span(d);
        if (len > ARRAY_CAP) len = ARRAY_CAP;
      end
      zero_pct = $urandom_range(90, 10);
      repeat (len) begin
        if ($urandom_range(99) < zero_pct) begin
          case ($urandom_range(3))
            0: begin
              lo = '0;
              hi = {$urandom, $urandom};
            end
            1: begin
              lo = {1'($urandom_range(1)), 31'd0, 1'($urandom_range(1)), 31'd0};
              hi = {1'($urandom_range(1)), 63'd0};
            end
            2: begin
              lo = {$urandom, $urandom} & ~64'hFF;
              hi = '0;
            end
            default: begin
              lo = {$urandom, $urandom} & 64'hFFFF_FFFF_0000_0000;
              hi = '0;
            end
          endcase
        end else begin
          case ($urandom_range(2))
            0: begin
              lo = {$urandom, $urandom};
              hi = {$urandom, $urandom};
            end
            1: begin
              lo = 64'd1 << $urandom_range(63);
              hi = '0;
            end
            default: begin
              lo = '0;
              hi = 64'd1 << $urandom_range(63);
            end
          endcase
        end
        push_elem(lo, hi);
        fed++;
      end
    end
  endtask

  initial begin
    plan_row_t         plan[$];
    logic [ELEM_W-1:0] lo;

    // After reset: bool, one dimension of one element, so every element is final
    plan.push_back(elem_row(64'h1, '0, 1'b1, 1'b1, 0, 0, 0, 0, 0, 1'b1));
    plan.push_back(elem_row(64'hFFFF_FFFF_FFFF_FF00, '1, 1'b1, 1'b0));
    // Scalar array
    plan.push_back(cfg_row(REG_DIMS_USED, 0));
    plan.push_back(cfg_row(REG_ELEM_TYPE, ET_I16));
    plan.push_back(elem_row(64'h8000, '0, 1'b1, 1'b1, 0, 0, 0, 0, 0, 1'b1));
    plan.push_back(elem_row(64'hFFFF_FFFF_FFFF_0000, '1, 1'b1, 1'b0));
    // 2 x 3 floats: minus zero is false, NaN is true
    plan.push_back(cfg_row(REG_ELEM_TYPE, ET_F32));
    plan.push_back(cfg_row(REG_DIMS_USED, 2));
    plan.push_back(cfg_row(REG_EXTENT_0, 2));
    plan.push_back(cfg_row(REG_EXTENT_1, 3));
    plan.push_back(elem_row(64'h8000_0000, '0, 1'b1, 1'b0));
    plan.push_back(elem_row(64'h7FC0_0000, '0, 1'b1, 1'b1, 0, 0, 1, 0, 0, 1'b0));
    plan.push_back(elem_row(64'h1, '0, 1'b1, 1'b1, 1, 0, 2, 0, 0, 1'b0));
    plan.push_back(elem_row(64'hFFFF_FFFF_0000_0000, '0, 1'b1, 1'b0));
    plan.push_back(elem_row(64'h3F80_0000, '0));
    plan.push_back(elem_row(64'hFFFF_FFFF, '0, 1'b1, 1'b1, 3, 1, 2, 0, 0, 1'b1));
    // Oversized dimension count and a zero extent, complex64
    plan.push_back(cfg_row(REG_ELEM_TYPE, ET_C64));
    plan.push_back(cfg_row(REG_DIMS_USED, 7));
    plan.push_back(cfg_row(REG_EXTENT_0, 0));
    plan.push_back(cfg_row(REG_EXTENT_1, 1));
    plan.push_back(cfg_row(REG_EXTENT_2, 2));
    plan.push_back(cfg_row(REG_EXTENT_3, 2));
    plan.push_back(elem_row(64'h8000_0000_8000_0000, '0, 1'b1, 1'b0));
    plan.push_back(elem_row(64'h0000_0001_0000_0000, '0, 1'b1, 1'b1, 0, 0, 0, 0, 1, 1'b0));
    plan.push_back(elem_row({$urandom, $urandom}, {$urandom, $urandom}));
    plan.push_back(elem_row(64'h8000_0001_8000_0000, '0));
    // Complex128, widest extent, then shrink it under a running array
    plan.push_back(cfg_row(REG_ELEM_TYPE, ET_C128));
    plan.push_back(cfg_row(REG_DIMS_USED, 1));
    plan.push_back(cfg_row(REG_EXTENT_0, '1));
    plan.push_back(elem_row(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 1'b1, 1'b0));
    plan.push_back(elem_row('0, 64'h1, 1'b1, 1'b1, 0, 1, 0, 0, 0, 1'b0));
    plan.push_back(elem_row(64'h7FF0_0000_0000_0000, '0, 1'b1, 1'b1, 1, 2, 0, 0, 0, 1'b0));
    plan.push_back(cfg_row(REG_EXTENT_0, 2));
    plan.push_back(elem_row(64'h1, '0, 1'b1, 1'b1, 2, 3, 0, 0, 0, 1'b1));
    plan.push_back(cfg_row(REG_ELEM_TYPE, ET_U64));
    plan.push_back(elem_row(64'h8000_0000_0000_0000, '0, 1'b1, 1'b1, 0, 0, 0, 0, 0, 1'b0));
    plan.push_back(elem_row('0, '1, 1'b1, 1'b0));
    plan.push_back(cfg_row(REG_ELEM_TYPE, ET_I8));
    plan.push_back(elem_row(64'hFFFF_FFFF_FFFF_FF80, '0));
    plan.push_back(cfg_row(REG_ELEM_TYPE, ET_F64));
    plan.push_back(elem_row(64'h8000_0000_0000_0000, '1, 1'b1, 1'b0));
    // Spare indexes change nothing; upper data bits of a narrow register drop
    plan.push_back(cfg_row(REG_SPARE, '1));
    plan.push_back(cfg_row(REG_SPARE_TOP, '1));
    plan.push_back(cfg_row(REG_ELEM_TYPE, '1));
    plan.push_back(elem_row('1, '1, 1'b1, 1'b0));
    plan.push_back(cfg_row(REG_ELEM_TYPE, ET_I64));
    plan.push_back(elem_row(64'h8000_0000_0000_0000, '0));

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        drain_results();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        push_elem(plan[i].lo, plan[i].hi, plan[i].known, plan[i].known_hit, plan[i].known_res);
      end
    end

    drain_results();
    run_random_arrays(250);
    send_idle_pct = 64;
    recv_idle_pct = 31;
    run_random_arrays(250);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_arrays(250);

    // One scalar beat clears the counters, then walk one short row end to end
    drain_results();
    write_reg(REG_DIMS_USED, 0);
    push_elem({$urandom, $urandom}, {$urandom, $urandom});
    drain_results();
    write_reg(REG_ELEM_TYPE, ET_BOOL);
    write_reg(REG_DIMS_USED, 1);
    write_reg(REG_EXTENT_0, CFG_DATA_W'(SWEEP_LEN));
    for (int i = 0; i < SWEEP_LEN; i++) begin
      if ($urandom_range(3) == 0 || i == SWEEP_LEN - 1)
        lo = {$urandom, $urandom} | 64'h1;
      else
        lo = {$urandom, $urandom} & ~64'hFF;
      push_elem(lo, {$urandom, $urandom});
    end

    drain_results();
    repeat (10) @(negedge clk);
    if (mismatches == 0 && pending_coords.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

>>> files.f
rtl/odc_pkg.sv
rtl/odc_truth.sv
rtl/odc_cell.sv
rtl/nonzero_coordinate_emitter_unit.sv
bench/tb_top.sv
